FILE: src/btbd_pkg.sv
// ----------------------------------------------------------------------------
// btbd_pkg: shared types and constants of the bass/treble beat detector
// Field widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package btbd_pkg;

	// Ring depth default
	localparam int RING_DEPTH_DEF = 64;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int BASS_W    = 24;
	localparam int TREBLE_W  = 26;
	localparam int BPEAK_W   = 24;
	localparam int TPEAK_W   = 25;
	localparam int OP_W      = 27;
	localparam int GAIN_W    = 20;
	localparam int RES_W     = 32;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	// Treble saturation bound
	localparam logic signed [RES_W-1:0] TREBLE_LIMIT = 32'sd25165312;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_PASS_GAIN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_PASS_GAIN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_FACTOR    = 8'd3;

	localparam logic [15:0] LOW_PASS_GAIN_RST  = 16'd39322;
	localparam logic [15:0] HIGH_PASS_GAIN_RST = 16'd39322;
	localparam logic [15:0] DECAY_GAIN_RST     = 16'd61604;
	localparam logic [7:0]  PEAK_FACTOR_RST    = 8'd32;

	// Register file contents
	typedef struct packed {
		logic [15:0] low_pass_gain;
		logic [15:0] high_pass_gain;
		logic [15:0] decay_gain;
		logic [7:0]  peak_factor;
	} cfg_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DECAY = 5'b01000,
		ST_CMP   = 5'b10000
	} state_t;

endpackage

FILE: src/btbd_ram.sv
// ----------------------------------------------------------------------------
// btbd_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module btbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/btbd_mul.sv
// ----------------------------------------------------------------------------
// btbd_mul: shared two-lane multiply and floor-shift unit
// Each lane returns floor(op * gain / 65536) for a signed operand.
// ----------------------------------------------------------------------------
module btbd_mul (
	input  logic signed [btbd_pkg::OP_W-1:0]  op_a,
	input  logic        [btbd_pkg::GAIN_W-1:0] gain_a,
	input  logic signed [btbd_pkg::OP_W-1:0]  op_b,
	input  logic        [btbd_pkg::GAIN_W-1:0] gain_b,
	output logic signed [btbd_pkg::RES_W-1:0] res_a,
	output logic signed [btbd_pkg::RES_W-1:0] res_b
);
	import btbd_pkg::*;

	localparam int PROD_W = OP_W + GAIN_W + 1;

	logic signed [PROD_W-1:0] prod_a;
	logic signed [PROD_W-1:0] prod_b;

	// Multiply; dropping the low 16 bits of a signed product rounds down
	assign prod_a = op_a * $signed({1'b0, gain_a});
	assign prod_b = op_b * $signed({1'b0, gain_b});
	assign res_a  = prod_a[PROD_W-1:16];
	assign res_b  = prod_b[PROD_W-1:16];

endmodule

FILE: src/btbd_cfg.sv
// ----------------------------------------------------------------------------
// btbd_cfg: configuration register file
// Holds the filter gains, the peak decay and the peak factor.
// ----------------------------------------------------------------------------
module btbd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [btbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [btbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output btbd_pkg::cfg_t                    regs
);
	import btbd_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Update the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.low_pass_gain  <= LOW_PASS_GAIN_RST;
			regs_q.high_pass_gain <= HIGH_PASS_GAIN_RST;
			regs_q.decay_gain     <= DECAY_GAIN_RST;
			regs_q.peak_factor    <= PEAK_FACTOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_PASS_GAIN:  regs_q.low_pass_gain  <= cfg_data;
				REG_HIGH_PASS_GAIN: regs_q.high_pass_gain <= cfg_data;
				REG_DECAY_GAIN:     regs_q.decay_gain     <= cfg_data;
				REG_PEAK_FACTOR:    regs_q.peak_factor    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: src/bass_treble_beat_detector_top.sv
// ----------------------------------------------------------------------------
// bass_treble_beat_detector_top: ring-replay bass/treble beat detector
//
// Usage:
//   s_axis carries one signed 16-bit sample per transfer. Each sample is
//   stored in a ring of RING_DEPTH entries; the ring is then replayed, oldest
//   to newest, through a low-pass and a high-pass one-pole filter, one entry
//   per cycle on a shared two-lane multiply unit. The decay and compare
//   states reuse it to decay peaks and test the final levels against them.
//   m_axis returns one result per sample: levels in tdata, beat flags in tuser.
//   cfg writes the four gain registers; issue them only while the block idles.
//   Each sample runs through the replay, decay and compare states, and the
//   compare state loads the output register; a new sample is taken only in
//   idle. The ring replay through the single memory read port sets the pace.
//   Reset: after arst_n releases, a clearing pass writes zeros to the ring,
//   during which s_axis_tready stays low.
//   A stalled m_axis holds the finished result; the next sample is still
//   taken and runs until its own result would overwrite the held one.
// ----------------------------------------------------------------------------
module bass_treble_beat_detector_top #(
	parameter int RING_DEPTH = btbd_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input samples
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [btbd_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [15:0] sample
	// Results
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [23:0] bass_level, [49:24] treble_level, [55:50] zero
	output logic [btbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [0] is_bass_peak, [1] is_treble_peak
	output logic [btbd_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	// Configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [btbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [btbd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import btbd_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
	localparam logic [AW:0]   ISS_END   = (AW+1)'(RING_DEPTH);

	cfg_t   regs;
	state_t state_q;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW:0]   iss_q;
	logic          dv_q;
	logic          last_q;
	logic          first_q;

	logic signed [BASS_W-1:0]   bass_q;
	logic signed [TREBLE_W-1:0] treble_q;
	logic signed [BASS_W-1:0]   xprev_q;
	logic [BPEAK_W-1:0]         bpeak_q;
	logic [TPEAK_W-1:0]         tpeak_q;

	logic                       out_bflag_q;
	logic                       out_tflag_q;
	logic signed [BASS_W-1:0]   out_bass_q;
	logic signed [TREBLE_W-1:0] out_treble_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [SAMPLE_W-1:0]        ram_wdata;
	logic [SAMPLE_W-1:0]        ram_rdata;

	logic signed [OP_W-1:0]     op_a;
	logic signed [OP_W-1:0]     op_b;
	logic [GAIN_W-1:0]          gain_a;
	logic [GAIN_W-1:0]          gain_b;
	logic signed [RES_W-1:0]    res_a;
	logic signed [RES_W-1:0]    res_b;

	logic signed [BASS_W-1:0]   x_cur;
	logic signed [RES_W-1:0]    bass_sum;
	logic signed [TREBLE_W-1:0] treble_sat;
	logic                       in_xfer;
	logic                       issue;
	logic                       out_free;
	logic                       bass_hit;
	logic                       treble_hit;
	logic [AW-1:0]              ptr_inc;
	logic [AW-1:0]              wr_inc;

	// Configuration registers
	btbd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Sample ring
	btbd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// Shared multiply unit
	btbd_mul u_mul (
		.op_a   (op_a),
		.gain_a (gain_a),
		.op_b   (op_b),
		.gain_b (gain_b),
		.res_a  (res_a),
		.res_b  (res_b)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign issue         = (state_q == ST_RUN) && (iss_q != ISS_END);
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign ptr_inc       = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
	assign wr_inc        = (wr_idx_q == LAST_ADDR) ? '0 : wr_idx_q + 1'b1;
	assign x_cur         = {ram_rdata, 8'b0};

	// Ring write: zeros during the clearing pass, the new sample on a transfer
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_idx_q;
		ram_wdata = s_axis_tdata;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = '0;
		end else if (in_xfer) begin
			ram_we = 1'b1;
		end
	end

	// Steer the multiply unit: filter step, peak decay or peak threshold
	always_comb begin
		op_a   = {{(OP_W-BASS_W){x_cur[BASS_W-1]}}, x_cur}
			- {{(OP_W-BASS_W){bass_q[BASS_W-1]}}, bass_q};
		op_b   = {{(OP_W-TREBLE_W){treble_q[TREBLE_W-1]}}, treble_q}
			+ {{(OP_W-BASS_W){x_cur[BASS_W-1]}}, x_cur}
			- {{(OP_W-BASS_W){xprev_q[BASS_W-1]}}, xprev_q};
		gain_a = {4'b0, regs.low_pass_gain};
		gain_b = {4'b0, regs.high_pass_gain};
		case (state_q)
			ST_DECAY: begin
				op_a   = {{(OP_W-BPEAK_W){1'b0}}, bpeak_q};
				op_b   = {{(OP_W-TPEAK_W){1'b0}}, tpeak_q};
				gain_a = {4'b0, regs.decay_gain};
				gain_b = {4'b0, regs.decay_gain};
			end
			ST_CMP: begin
				op_a   = {{(OP_W-BPEAK_W){1'b0}}, bpeak_q};
				op_b   = {{(OP_W-TPEAK_W){1'b0}}, tpeak_q};
				gain_a = {regs.peak_factor, 12'b0};
				gain_b = {regs.peak_factor, 12'b0};
			end
			default: ;
		endcase
	end

	// Filter updates and threshold tests
	always_comb begin
		bass_sum   = {{(RES_W-BASS_W){bass_q[BASS_W-1]}}, bass_q} + res_a;
		treble_sat = res_b[TREBLE_W-1:0];
		if (res_b > TREBLE_LIMIT) begin
			treble_sat = TREBLE_LIMIT[TREBLE_W-1:0];
		end else if (res_b < -TREBLE_LIMIT) begin
			treble_sat = -TREBLE_LIMIT[TREBLE_W-1:0];
		end
		bass_hit   = $signed({{(RES_W-BASS_W){bass_q[BASS_W-1]}}, bass_q}) > res_a;
		treble_hit = $signed({{(RES_W-TREBLE_W){treble_q[TREBLE_W-1]}}, treble_q})
			> res_b;
	end

	// Sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			ptr_q    <= '0;
			wr_idx_q <= '0;
			iss_q    <= '0;
			dv_q     <= 1'b0;
			last_q   <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			dv_q   <= issue;
			last_q <= issue && (iss_q == ISS_END - 1'b1);
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_inc;
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						wr_idx_q <= wr_inc;
						ptr_q    <= wr_inc;
						iss_q    <= '0;
						first_q  <= 1'b1;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						ptr_q <= ptr_inc;
						iss_q <= iss_q + 1'b1;
					end
					if (dv_q) begin
						first_q <= 1'b0;
					end
					if (dv_q && last_q) begin
						state_q <= ST_DECAY;
					end
				end
				ST_DECAY: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Filter state: seed from the oldest entry, then step once per entry
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && dv_q) begin
			xprev_q <= x_cur;
			if (first_q) begin
				bass_q   <= x_cur;
				treble_q <= {{(TREBLE_W-BASS_W){x_cur[BASS_W-1]}}, x_cur};
			end else begin
				bass_q   <= bass_sum[BASS_W-1:0];
				treble_q <= treble_sat;
			end
		end
	end

	// Peaks: decay each item, take the level on a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpeak_q <= '0;
			tpeak_q <= '0;
		end else if (state_q == ST_DECAY) begin
			bpeak_q <= res_a[BPEAK_W-1:0];
			tpeak_q <= res_b[TPEAK_W-1:0];
		end else if (state_q == ST_CMP && out_free) begin
			if (bass_hit) begin
				bpeak_q <= bass_q;
			end
			if (treble_hit) begin
				tpeak_q <= treble_q[TPEAK_W-1:0];
			end
		end
	end

	// Output register: load on the compare step, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == ST_CMP && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP && out_free) begin
			out_bflag_q  <= bass_hit;
			out_tflag_q  <= treble_hit;
			out_bass_q   <= bass_q;
			out_treble_q <= treble_q;
		end
	end

	assign m_axis_tdata = {{(OUT_DATA_W-BASS_W-TREBLE_W){1'b0}}, out_treble_q, out_bass_q};
	assign m_axis_tuser = {out_tflag_q, out_bflag_q};

	// Checks
	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_RUN))
		else $error("accepted sample did not start the ring replay");

	a_read_data_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		dv_q |-> (state_q == ST_RUN))
		else $error("ring read data arrived outside the replay");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("input ready during the clearing pass");

	a_treble_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(out_treble_q) <= $signed(TREBLE_LIMIT[TREBLE_W-1:0])
			&& $signed(out_treble_q) >= $signed(-TREBLE_LIMIT[TREBLE_W-1:0])))
		else $error("treble level outside the saturation bound");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (iss_q <= ISS_END))
		else $error("replay issued past the ring depth");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bass_treble_beat_detector_top
// Streams signed samples into the detector, predicts every result with a
// behavioral model of the ring replay, both one-pole filters and the decaying
// peak tests, and compares levels and beat flags field by field. Both stream
// sides idle at random; the gain registers are swept between phases.
// ----------------------------------------------------------------------------
module testbench;

	import btbd_pkg::*;

	localparam int RING = RING_DEPTH_DEF;

	// One expected result: beat flags and both filter levels
	typedef struct packed {
		logic                bass_hit;
		logic                treble_hit;
		logic [BASS_W-1:0]   bass_lvl;
		logic [TREBLE_W-1:0] treble_lvl;
	} beat_t;

	// Shapes of random sample runs
	typedef enum int {SEG_NOISE, SEG_QUIET, SEG_HITS, SEG_SQUARE, SEG_RAIL} seg_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Detector model state
	logic signed [SAMPLE_W-1:0] sample_hist [RING];
	int                         wr_ptr;
	longint                     bass_pk;
	longint                     treble_pk;
	cfg_t                       gains;

	beat_t pending_beats [$];
	int    fault_count;
	int    results_seen;

	// Idle pattern state of the sample source and the result sink
	int tx_stretch;
	bit tx_calm;
	int rx_stretch;
	bit rx_calm;

	bass_treble_beat_detector_top #(
		.RING_DEPTH(RING)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#(12 * 600000);
		$display("*** FAILED ***");
		$finish;
	end

	// Draw a random wait, none in a calm run; each run of items is drawn busy or calm at random
	function automatic int pick_wait(ref int stretch, ref bit calm);
		if (stretch == 0) begin
			stretch = $urandom_range(4, 40);
			calm = ($urandom_range(0, 2) == 0);
		end
		stretch--;
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// Store the sample, replay the ring through both filters, test the peaks
	function automatic beat_t predict_beat(logic [SAMPLE_W-1:0] smp);
		beat_t  r;
		longint bass, treble, x, xp;
		int     j;
		sample_hist[wr_ptr] = smp;
		wr_ptr = (wr_ptr + 1) % RING;
		bass = longint'(sample_hist[wr_ptr]) * 256;
		treble = bass;
		for (int i = 1; i < RING; i++) begin
			j  = (wr_ptr + i) % RING;
			x  = longint'(sample_hist[j]) * 256;
			xp = longint'(sample_hist[(j + RING - 1) % RING]) * 256;
			// floor of a Q0.16 product is an arithmetic shift
			bass   = bass + ((longint'(gains.low_pass_gain) * (x - bass)) >>> 16);
			treble = (longint'(gains.high_pass_gain) * (treble + x - xp)) >>> 16;
			if (treble > longint'(TREBLE_LIMIT))
				treble = longint'(TREBLE_LIMIT);
			if (treble < -longint'(TREBLE_LIMIT))
				treble = -longint'(TREBLE_LIMIT);
		end
		// Decay each peak, then compare exactly against peak times Q4.4 factor
		bass_pk = (bass_pk * longint'(gains.decay_gain)) >>> 16;
		r.bass_hit = (bass * 16 > bass_pk * longint'(gains.peak_factor));
		if (r.bass_hit)
			bass_pk = bass;
		treble_pk = (treble_pk * longint'(gains.decay_gain)) >>> 16;
		r.treble_hit = (treble * 16 > treble_pk * longint'(gains.peak_factor));
		if (r.treble_hit)
			treble_pk = treble;
		r.bass_lvl   = bass[BASS_W-1:0];
		r.treble_lvl = treble[TREBLE_W-1:0];
		return r;
	endfunction

	// Send one sample after a random gap; valid stays high for a back-to-back item
	task automatic send_sample(logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = pick_wait(tx_stretch, tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		pending_beats.push_back(predict_beat(smp));
	endtask

	// Write one register; hold valid when another write follows
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_LOW_PASS_GAIN:  gains.low_pass_gain  = val;
			REG_HIGH_PASS_GAIN: gains.high_pass_gain = val;
			REG_DECAY_GAIN:     gains.decay_gain     = val;
			REG_PEAK_FACTOR:    gains.peak_factor    = val[7:0];
			default: ;
		endcase
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	// Drop valid, drain all results, then let the pipeline go quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (RING + 8) @(posedge clk);
	endtask

	// Field extremes, bit patterns, a loud burst, silence and full-swing toggling
	task automatic test_reset_values();
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		repeat (4) send_sample(16'h7FFF);
		repeat (4) send_sample(16'h0000);
		repeat (3) begin
			send_sample(16'h7FFF);
			send_sample(16'h8000);
		end
		send_sample(16'h8000);
		send_sample(16'h8000);
	endtask

	// Out-of-range indexes are dropped; the factor keeps only its low byte
	task automatic test_register_decode();
		settle();
		write_reg(REG_PEAK_FACTOR + 8'd1, 16'($urandom), 1'b1);
		write_reg(8'hFF, 16'hFFFF, 1'b1);
		write_reg(8'h80, 16'h0000, 1'b1);
		write_reg(8'h7F, 16'($urandom), 1'b1);
		write_reg(REG_PEAK_FACTOR, {8'hC3, 8'd24}, 1'b0);
		repeat (4) send_sample(16'($urandom));
		repeat (2) send_sample(16'h7FFF);
		repeat (2) send_sample(16'h0000);
	endtask

	// Random audio-like runs: noise, quiet passages, isolated hits, squares, rails
	task automatic play_random(int count);
		seg_t              style;
		int                left;
		int                period;
		int                tick;
		logic [14:0]       amp;
		logic [31:0]       r;
		logic [SAMPLE_W-1:0] v;
		left = 0;
		style = SEG_NOISE;
		period = 1;
		tick = 0;
		amp = '0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				style  = seg_t'($urandom_range(0, 4));
				left   = $urandom_range(4, 30);
				period = $urandom_range(1, 8);
				amp    = 15'($urandom);
				tick   = 0;
			end
			left--;
			r = $urandom;
			case (style)
				SEG_NOISE:  v = r[15:0];
				SEG_QUIET:  v = {{9{r[6]}}, r[6:0]};
				SEG_HITS: begin
					if (r[31:29] == 3'd0)
						v = r[28] ? (16'h7FFF - {10'd0, r[5:0]}) : (16'h8000 + {10'd0, r[5:0]});
					else
						v = {{9{r[6]}}, r[6:0]};
				end
				SEG_SQUARE: v = ((tick / period) % 2 == 0) ? {1'b0, amp} : -{1'b0, amp};
				default:    v = r[0] ? 16'h7FFF : 16'h8000;
			endcase
			tick++;
			send_sample(v);
		end
	endtask

	// Sweep all registers through extremes, random settings and the reset values
	task automatic test_gain_sweep();
		logic [15:0] lp, hp, dg;
		logic [7:0]  pf;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin lp = 16'hFFFF; hp = 16'hFFFF; dg = 16'hFFFF; pf = 8'hFF; end
				1: begin lp = 16'h0000; hp = 16'h0000; dg = 16'h0000; pf = 8'h00; end
				3: begin lp = 16'h0001; hp = 16'hFFFF; dg = DECAY_GAIN_RST; pf = 8'd16; end
				5: begin
					lp = LOW_PASS_GAIN_RST;
					hp = HIGH_PASS_GAIN_RST;
					dg = DECAY_GAIN_RST;
					pf = PEAK_FACTOR_RST;
				end
				default: begin
					lp = 16'($urandom);
					hp = 16'($urandom);
					dg = 16'($urandom_range(32768, 65535));
					pf = 8'($urandom);
				end
			endcase
			settle();
			write_reg(REG_LOW_PASS_GAIN, lp, 1'b1);
			write_reg(REG_HIGH_PASS_GAIN, hp, 1'b1);
			write_reg(REG_DECAY_GAIN, dg, 1'b1);
			write_reg(REG_PEAK_FACTOR, {8'($urandom), pf}, 1'b0);
			play_random(135);
		end
	endtask

	// Accept results with random stalls and compare against the oldest prediction
	initial begin : result_sink
		int    stall;
		beat_t want;
		beat_t got;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_wait(rx_stretch, rx_calm);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			got.bass_hit   = m_axis_tuser[0];
			got.treble_hit = m_axis_tuser[1];
			got.bass_lvl   = m_axis_tdata[BASS_W-1:0];
			got.treble_lvl = m_axis_tdata[BASS_W +: TREBLE_W];
			results_seen++;
			if (pending_beats.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result %0d arrived with nothing expected: tdata %h tuser %b",
						results_seen, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want || m_axis_tdata[OUT_DATA_W-1:BASS_W+TREBLE_W] !== '0) begin
					fault_count++;
					// levels as bass/flag and treble/flag, expected first
					if (fault_count <= 10)
						$display(
							"result %0d: want b %0d/%b t %0d/%b, got b %0d/%b t %0d/%b, pad %h",
							results_seen, $signed(want.bass_lvl), want.bass_hit,
							$signed(want.treble_lvl), want.treble_hit,
							$signed(got.bass_lvl), got.bass_hit,
							$signed(got.treble_lvl), got.treble_hit,
							m_axis_tdata[OUT_DATA_W-1:BASS_W+TREBLE_W]);
				end
			end
		end
	end

	// Reset, run each test in turn, drain and report
	initial begin : sequencer
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		fault_count   = 0;
		results_seen  = 0;
		tx_stretch    = 0;
		tx_calm       = 1'b0;
		rx_stretch    = 0;
		rx_calm       = 1'b0;
		wr_ptr        = 0;
		bass_pk       = 0;
		treble_pk     = 0;
		foreach (sample_hist[k])
			sample_hist[k] = '0;
		gains.low_pass_gain  = LOW_PASS_GAIN_RST;
		gains.high_pass_gain = HIGH_PASS_GAIN_RST;
		gains.decay_gain     = DECAY_GAIN_RST;
		gains.peak_factor    = PEAK_FACTOR_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_decode();
		test_gain_sweep();

		settle();
		if (fault_count == 0 && pending_beats.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
src/btbd_pkg.sv
src/btbd_ram.sv
src/btbd_mul.sv
src/btbd_cfg.sv
src/bass_treble_beat_detector_top.sv
sim/testbench.sv
